FILE: src/csd_pkg.sv
`default_nettype none

package csd_pkg;

	localparam int NUM_SLOTS = 4;
	localparam int CFG_IDX_W = 2;
	localparam int DIV_W     = 35;  // (far - near) * slot number
	localparam int DIV_STEPS = 7;   // quotient bits per divider stage
	localparam int DIV_STG   = DIV_W / DIV_STEPS;

	localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CASCADE_COUNT = 2'd1;

	localparam logic [31:0] DEPTH_EPS  = 32'd66;
	localparam logic [16:0] WEIGHT_ONE = 17'd65536;
	localparam logic [16:0] EXP_C1     = 17'd45600;
	localparam logic [16:0] EXP_C2     = 17'd14752;
	localparam logic [16:0] EXP_C3     = 17'd5184;

	typedef struct packed {
		logic [2:0]       rem;
		logic [DIV_W-1:0] dq;
	} div_st_t;

endpackage

`default_nettype wire

FILE: src/cascade_split_depth_calculator_unit.sv
// Cascade split depth calculator. Each word on the input (near_depth, far_depth, unsigned
// Q16.16) yields one word of four cascade far boundaries, a rounded blend of the linear and
// logarithmic splits set by blend_weight; the last active slot and unused slots carry far.
// Fully pipelined: one word per clock unless out_stall holds a valid output word. Most stages
// are in the log2 unit (16 squaring stages) and the divide-by-count unit (5 stages of 7 bits).
// blend_weight and cascade_count may be written only while the pipeline is empty.
`default_nettype none

module cascade_split_depth_calculator_unit
	import csd_pkg::*;
#(
	parameter int MAX_CASCADES = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [16:0]          cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [31:0]          near_depth,
	input  wire logic [31:0]          far_depth,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [31:0]               split_zero,
	output logic [31:0]               split_one,
	output logic [31:0]               split_two,
	output logic [31:0]               split_three
);

	localparam int LAST = 31;

	logic [16:0] blend_weight_q;
	logic [2:0]  cascade_count_q;
	logic [16:0] w_eff;
	logic [2:0]  cnt_eff;
	logic        advance;
	logic        vld [1:LAST];

	function automatic logic [4:0] msb_pos(input logic [31:0] x);
		logic [4:0] p;
		p = '0;
		for (int i = 0; i < 32; i++) begin
			if (x[i]) p = 5'(i);
		end
		return p;
	endfunction

	// one log2 fraction bit: square Q1.31 mantissa, renormalize
	function automatic logic [32:0] sq_step(input logic [31:0] m);
		logic [63:0] p;
		logic [32:0] t;
		p = 64'(m) * 64'(m);
		t = p[63:31];
		if (t[32]) return {1'b1, t[32:1]};
		return {1'b0, t[31:0]};
	endfunction

	function automatic div_st_t div_chunk(input div_st_t s, input logic [2:0] d);
		div_st_t    r;
		logic [3:0] r4;
		r = s;
		for (int i = 0; i < DIV_STEPS; i++) begin
			r4   = {r.rem, r.dq[DIV_W-1]};
			r.dq = {r.dq[DIV_W-2:0], 1'b0};
			if (r4 >= {1'b0, d}) begin
				r.dq[0] = 1'b1;
				r.rem   = 3'(r4 - {1'b0, d});
			end else begin
				r.rem = r4[2:0];
			end
		end
		return r;
	endfunction

	function automatic logic [16:0] horner(input logic [16:0] c, input logic [16:0] t,
			input logic [15:0] f);
		logic [33:0] p;
		p = 34'(t) * 34'(f);
		return 17'(c + 17'(p[33:16]));
	endfunction

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_weight_q  <= 17'd32768;
			cascade_count_q <= 3'd4;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_BLEND_WEIGHT:  blend_weight_q  <= cfg_data;
				REG_CASCADE_COUNT: cascade_count_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		w_eff = (blend_weight_q > WEIGHT_ONE) ? WEIGHT_ONE : blend_weight_q;
		cnt_eff = cascade_count_q;
		if (cnt_eff == 3'd0) cnt_eff = 3'd1;
		if (int'(cnt_eff) > MAX_CASCADES) cnt_eff = 3'(MAX_CASCADES);
	end

	assign advance   = !vld[LAST] || !out_stall;
	assign in_stall  = !advance;
	assign out_valid = vld[LAST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LAST; i++) vld[i] <= 1'b0;
		end else if (advance) begin
			vld[1] <= in_valid;
			for (int i = 2; i <= LAST; i++) vld[i] <= vld[i-1];
		end
	end

	// s1: clamp inputs
	logic [31:0] nr_s1, fr_s1;
	logic [31:0] nr_c, minfar_sat;
	logic [32:0] minfar;

	always_comb begin
		nr_c       = (near_depth < DEPTH_EPS) ? DEPTH_EPS : near_depth;
		minfar     = 33'(nr_c) + 33'(DEPTH_EPS);
		minfar_sat = minfar[32] ? 32'hFFFF_FFFF : minfar[31:0];
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			nr_s1 <= nr_c;
			fr_s1 <= (far_depth < minfar_sat) ? minfar_sat : far_depth;
		end
	end

	// s2..s18: normalize, then 16 squaring stages; index j is stage s(2+j)
	logic [31:0] lm_n_s  [0:16];
	logic [31:0] lm_f_s  [0:16];
	logic [15:0] fr_n_s  [0:16];
	logic [15:0] fr_f_s  [0:16];
	logic [4:0]  ex_n_s  [0:16];
	logic [4:0]  ex_f_s  [0:16];
	logic [31:0] nr_l_s  [0:16];
	logic [31:0] fr_l_s  [0:16];
	logic [4:0]  e_n, e_f;

	assign e_n = msb_pos(nr_s1);
	assign e_f = msb_pos(fr_s1);

	always_ff @(posedge clk) begin
		logic [32:0] sn, sf;
		if (advance) begin
			lm_n_s[0] <= nr_s1 << (5'd31 - e_n);
			lm_f_s[0] <= fr_s1 << (5'd31 - e_f);
			fr_n_s[0] <= '0;
			fr_f_s[0] <= '0;
			ex_n_s[0] <= e_n;
			ex_f_s[0] <= e_f;
			nr_l_s[0] <= nr_s1;
			fr_l_s[0] <= fr_s1;
			for (int j = 1; j <= 16; j++) begin
				sn = sq_step(lm_n_s[j-1]);
				sf = sq_step(lm_f_s[j-1]);
				lm_n_s[j] <= sn[31:0];
				lm_f_s[j] <= sf[31:0];
				fr_n_s[j] <= {fr_n_s[j-1][14:0], sn[32]};
				fr_f_s[j] <= {fr_f_s[j-1][14:0], sf[32]};
				ex_n_s[j] <= ex_n_s[j-1];
				ex_f_s[j] <= ex_f_s[j-1];
				nr_l_s[j] <= nr_l_s[j-1];
				fr_l_s[j] <= fr_l_s[j-1];
			end
		end
	end

	// s19: differences times slot number; s20..s24: divide by count
	logic [20:0] ln_c, lf_c;
	div_st_t     dl_s [0:DIV_STG][NUM_SLOTS];
	div_st_t     dg_s [0:DIV_STG][NUM_SLOTS];
	logic [31:0] nr_d_s [0:DIV_STG];
	logic [31:0] fr_d_s [0:DIV_STG];
	logic [20:0] ln_d_s [0:DIV_STG];

	always_comb begin
		ln_c = {ex_n_s[16], fr_n_s[16]};
		lf_c = {ex_f_s[16], fr_f_s[16]};
		if (lf_c < ln_c) lf_c = ln_c;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			nr_d_s[0] <= nr_l_s[16];
			fr_d_s[0] <= fr_l_s[16];
			ln_d_s[0] <= ln_c;
			for (int k = 0; k < NUM_SLOTS; k++) begin
				dl_s[0][k].rem <= '0;
				dg_s[0][k].rem <= '0;
				dl_s[0][k].dq  <= DIV_W'(fr_l_s[16] - nr_l_s[16]) * DIV_W'(3'(k + 1));
				dg_s[0][k].dq  <= DIV_W'(lf_c - ln_c) * DIV_W'(3'(k + 1));
			end
			for (int j = 1; j <= DIV_STG; j++) begin
				nr_d_s[j] <= nr_d_s[j-1];
				fr_d_s[j] <= fr_d_s[j-1];
				ln_d_s[j] <= ln_d_s[j-1];
				for (int k = 0; k < NUM_SLOTS; k++) begin
					dl_s[j][k] <= div_chunk(dl_s[j-1][k], cnt_eff);
					dg_s[j][k] <= div_chunk(dg_s[j-1][k], cnt_eff);
				end
			end
		end
	end

	// s25..s31: linear split, exp2, clamp, blend
	logic [31:0] lin_s25 [NUM_SLOTS], lin_s26 [NUM_SLOTS], lin_s27 [NUM_SLOTS];
	logic [31:0] lin_s28 [NUM_SLOTS], lin_s29 [NUM_SLOTS];
	logic [4:0]  ip_s25 [NUM_SLOTS], ip_s26 [NUM_SLOTS], ip_s27 [NUM_SLOTS];
	logic [4:0]  ip_s28 [NUM_SLOTS];
	logic [15:0] f_s25 [NUM_SLOTS], f_s26 [NUM_SLOTS], f_s27 [NUM_SLOTS];
	logic [16:0] t_s26 [NUM_SLOTS], t_s27 [NUM_SLOTS];
	logic [17:0] mant_s28 [NUM_SLOTS];
	logic [31:0] lgs_s29 [NUM_SLOTS];
	logic [48:0] pl_s30 [NUM_SLOTS], pg_s30 [NUM_SLOTS];
	logic [31:0] res_s31 [NUM_SLOTS];
	logic [31:0] nr_s25, nr_s26, nr_s27, nr_s28;
	logic [31:0] fr_s25, fr_s26, fr_s27, fr_s28, fr_s29, fr_s30;

	always_ff @(posedge clk) begin
		logic [20:0] lg;
		logic [33:0] sh;
		logic [31:0] v;
		logic [49:0] sum;
		if (advance) begin
			nr_s25 <= nr_d_s[DIV_STG];
			fr_s25 <= fr_d_s[DIV_STG];
			nr_s26 <= nr_s25;  fr_s26 <= fr_s25;
			nr_s27 <= nr_s26;  fr_s27 <= fr_s26;
			nr_s28 <= nr_s27;  fr_s28 <= fr_s27;
			fr_s29 <= fr_s28;  fr_s30 <= fr_s29;
			for (int k = 0; k < NUM_SLOTS; k++) begin
				lin_s25[k] <= nr_d_s[DIV_STG] + dl_s[DIV_STG][k].dq[31:0];
				lg = ln_d_s[DIV_STG] + dg_s[DIV_STG][k].dq[20:0];
				ip_s25[k]  <= lg[20:16];
				f_s25[k]   <= lg[15:0];

				t_s26[k]   <= horner(EXP_C2, EXP_C3, f_s25[k]);
				f_s26[k]   <= f_s25[k];
				ip_s26[k]  <= ip_s25[k];
				lin_s26[k] <= lin_s25[k];

				t_s27[k]   <= horner(EXP_C1, t_s26[k], f_s26[k]);
				f_s27[k]   <= f_s26[k];
				ip_s27[k]  <= ip_s26[k];
				lin_s27[k] <= lin_s26[k];

				mant_s28[k] <= 18'(horner(17'd0, t_s27[k], f_s27[k])) + 18'd65536;
				ip_s28[k]   <= ip_s27[k];
				lin_s28[k]  <= lin_s27[k];

				if (ip_s28[k] >= 5'd16) begin
					sh = 34'(mant_s28[k]) << (ip_s28[k] - 5'd16);
					v  = (sh > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : sh[31:0];
				end else begin
					v = 32'(mant_s28[k] >> (5'd16 - ip_s28[k]));
				end
				if (v < nr_s28) v = nr_s28;
				if (v > fr_s28) v = fr_s28;
				lgs_s29[k] <= v;
				lin_s29[k] <= lin_s28[k];

				pl_s30[k] <= 49'(lin_s29[k]) * 49'(WEIGHT_ONE - w_eff);
				pg_s30[k] <= 49'(lgs_s29[k]) * 49'(w_eff);

				sum = 50'(pl_s30[k]) + 50'(pg_s30[k]) + 50'd32768;
				if (k + 1 < int'(cnt_eff))
					res_s31[k] <= (sum[49:48] != 2'b00) ? 32'hFFFF_FFFF : sum[47:16];
				else
					res_s31[k] <= fr_s30;
			end
		end
	end

	assign split_zero  = res_s31[0];
	assign split_one   = res_s31[1];
	assign split_two   = res_s31[2];
	assign split_three = res_s31[3];

endmodule

`default_nettype wire
